// File: rtl/buddy_block_allocator_top_defines.svh
// Assertion helpers for the buddy allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bba_pkg.sv
package bba_pkg;

    localparam int MAX_LEVEL    = 10;
    localparam int LVL_W        = 4;
    localparam int UNIT_W       = MAX_LEVEL;
    localparam int ARENA_UNITS  = 1 << UNIT_W;
    localparam int HEADS        = MAX_LEVEL + 1;
    localparam int BLOCK_BYTES  = 40;
    localparam int HEADER_BYTES = 40;
    localparam int ADDR_BIAS    = 8;
    localparam int LEN_W        = 16;
    localparam int ADDR_W       = 16;
    localparam int NEED_W       = 17;
    // Block size is 8 * 5 bytes: divide by 5 through a reciprocal
    localparam int QUO_W        = 13;
    localparam int U5_W         = 11;
    localparam int RECIP5_MULT  = 52429;
    localparam int RECIP5_SHIFT = 18;
    localparam int PROD_W       = 29;

    typedef logic [LVL_W-1:0]  lvl_t;
    typedef logic [UNIT_W-1:0] unit_t;

    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_ROOT  = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_NOFIT = 2'd1,
        STATUS_NULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic       valid;
        logic       used;
        lvl_t       level;
        logic [1:0] side;
        logic [1:0] inherit;
        logic       has_next;
        logic       has_prev;
        unit_t      next;
        unit_t      prev;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_FIT,
        ST_A_FIND,
        ST_S_RD,
        ST_S_GET,
        ST_S_PUSHR,
        ST_S_PUSHL,
        ST_S_NEXT,
        ST_T_RD,
        ST_T_GET,
        ST_T_FIN,
        ST_R_DIV,
        ST_R_CHK,
        ST_R_GET,
        ST_M_RD,
        ST_M_GET,
        ST_M_BUD,
        ST_M_CHK,
        ST_M_SWAP,
        ST_M_GETB,
        ST_M_JOIN,
        ST_U_PREV,
        ST_U_PREVW,
        ST_U_NEXT,
        ST_U_NEXTW,
        ST_U_END,
        ST_P_HEAD,
        ST_P_HEADW,
        ST_P_END,
        ST_DONE
    } state_t;

    // Clamp a stored level into the list range
    function automatic lvl_t bba_lvl(input lvl_t l);
        lvl_t r;
        r = (l > lvl_t'(MAX_LEVEL)) ? lvl_t'(MAX_LEVEL) : l;
        return r;
    endfunction

    // Saturate a written arena level into 1..MAX_LEVEL
    function automatic lvl_t bba_sat(input lvl_t l);
        lvl_t r;
        if (l == lvl_t'(0))
        begin
            r = lvl_t'(1);
        end
        else if (l > lvl_t'(MAX_LEVEL))
        begin
            r = lvl_t'(MAX_LEVEL);
        end
        else
        begin
            r = l;
        end
        return r;
    endfunction

endpackage

// File: rtl/bba_if.sv
// Request channel: one allocate or release word
interface bba_req_if
    import bba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              op;
    logic [LEN_W-1:0]  request_length;
    logic [ADDR_W-1:0] release_address;

    modport source (output valid, output op, output request_length,
                    output release_address, input ready);
    modport sink (input valid, input op, input request_length,
                  input release_address, output ready);
endinterface

// Response channel: one address and status word
interface bba_rsp_if
    import bba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic [1:0]        status;

    modport source (output valid, output address, output status, input ready);
    modport sink (input valid, input address, input status, output ready);
endinterface

// File: rtl/buddy_block_allocator_top.sv
// Binary buddy allocator over 40-byte units, up to 1024 units. Block headers
// live in one 1024-entry RAM with a registered read; the per-level free-list
// heads live in flops. One word is worked on at a time. Each step is a chain
// of header reads and writes through the single RAM read port. A request word
// may be taken while the previous response still waits. After reset and after
// every top_level write a clearing pass over all 1024 headers rebuilds the
// arena; no request is taken during it.
module buddy_block_allocator_top
    import bba_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [3:0]    cfg_wdata,
    bba_req_if.sink       req,
    bba_rsp_if.source     rsp
);

`include "buddy_block_allocator_top_defines.svh"

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    lvl_t                top_reg, top_next;
    logic [HEADS-1:0]    head_ok_reg, head_ok_next;
    unit_t               head_at_reg [HEADS];
    unit_t               head_at_next [HEADS];
    unit_t               clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    status_t             out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    status_t             res_status_reg, res_status_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [ADDR_W-1:0]   rel_reg, rel_next;
    unit_t               u_reg, u_next;
    unit_t               aux_reg, aux_next;
    hdr_t                hdr_reg, hdr_next;
    hdr_t                save_reg, save_next;
    lvl_t                v_reg, v_next;
    lvl_t                k_reg, k_next;
    logic [QUO_W-1:0]    q_reg, q_next;
    logic [U5_W-1:0]     u5_reg, u5_next;
    logic                rel_ok_reg, rel_ok_next;

    logic                mem_we;
    unit_t               mem_waddr;
    hdr_t                mem_wdata;
    unit_t               mem_raddr;
    logic [HDR_W-1:0]    ram_rdata;
    hdr_t                bh;

    lvl_t                cur_lvl;
    lvl_t                head_lvl;
    unit_t               head_at_sel;
    logic                head_ok_sel;
    logic [NEED_W-1:0]   need;
    logic                fit_found;
    lvl_t                fit_v;
    logic                k_found;
    lvl_t                k_sel;
    logic [UNIT_W:0]     bud_size;
    logic [UNIT_W:0]     bud_sum;
    logic                bud_ok;
    unit_t               bud_addr;
    logic                bud_match;
    logic                merge_go;
    logic [QUO_W-1:0]    u5_times5;
    logic                rel_chk_ok;
    logic [ADDR_W-1:0]   off;
    logic [PROD_W-1:0]   prod;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [HEADS-1:0]    above_top_mask;

    bba_ram #(
        .WIDTH (HDR_W),
        .DEPTH (ARENA_UNITS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (ram_rdata)
    );

    assign bh = hdr_t'(ram_rdata);

    // Ports
    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.address = out_addr_reg;
    assign rsp.status  = out_status_reg;

    // Select the free-list head being looked at
    assign cur_lvl = bba_lvl(hdr_reg.level);
    always_comb
    begin
        case (state_reg)
            ST_S_RD: head_lvl = k_reg;
            ST_T_RD: head_lvl = v_reg;
            default: head_lvl = cur_lvl;
        endcase
    end
    assign head_at_sel = head_at_reg[head_lvl];
    assign head_ok_sel = head_ok_reg[head_lvl];

    // Find the smallest fitting level
    assign need = NEED_W'(len_reg) + NEED_W'(HEADER_BYTES);
    always_comb
    begin
        fit_found = 1'b0;
        fit_v     = lvl_t'(1);
        for (int lv = MAX_LEVEL; lv >= 1; lv--)
        begin
            if (((NEED_W'(BLOCK_BYTES) << lv) >= need) && (lvl_t'(lv) <= top_reg))
            begin
                fit_found = 1'b1;
                fit_v     = lvl_t'(lv);
            end
        end
    end

    // Find the smallest non-empty list at or above the fitting level
    always_comb
    begin
        k_found = 1'b0;
        k_sel   = lvl_t'(1);
        for (int lv = MAX_LEVEL; lv >= 1; lv--)
        begin
            if (head_ok_reg[lv] && (lvl_t'(lv) >= v_reg) && (lvl_t'(lv) <= top_reg))
            begin
                k_found = 1'b1;
                k_sel   = lvl_t'(lv);
            end
        end
    end

    // Locate the buddy of the current block
    assign bud_size = (UNIT_W+1)'(1) << cur_lvl;
    assign bud_sum  = {1'b0, u_reg} + bud_size;
    assign merge_go = (cur_lvl < top_reg);
    always_comb
    begin
        bud_ok   = 1'b0;
        bud_addr = u_reg;
        if (hdr_reg.side == SIDE_LEFT)
        begin
            bud_ok   = !bud_sum[UNIT_W];
            bud_addr = bud_sum[UNIT_W-1:0];
        end
        else if (hdr_reg.side == SIDE_RIGHT)
        begin
            bud_ok   = ({1'b0, u_reg} >= bud_size);
            bud_addr = u_reg - bud_size[UNIT_W-1:0];
        end
    end
    assign bud_match = bh.valid && !bh.used && (bh.level == cur_lvl);

    // Turn a release address into a unit index
    assign off        = rel_reg - ADDR_W'(ADDR_BIAS);
    assign prod       = PROD_W'(off[ADDR_W-1:3]) * PROD_W'(RECIP5_MULT);
    assign u5_times5  = {u5_reg, 2'b00} + QUO_W'(u5_reg);
    assign rel_chk_ok = rel_ok_reg && (u5_times5 == q_reg)
                        && (u5_reg < ((U5_W)'(1) << top_reg));

    assign alloc_addr = ADDR_W'({u_reg, 5'b0}) + ADDR_W'({u_reg, 3'b0})
                        + ADDR_W'(ADDR_BIAS);

    always_comb
    begin
        for (int i = 0; i < HEADS; i++)
        begin
            above_top_mask[i] = (lvl_t'(i) > top_reg);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.op == OP_ALLOC)
                    begin
                        state_next = ST_A_FIT;
                    end
                    else if (req.release_address == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_R_DIV;
                    end
                end
            end
            ST_A_FIT:   state_next = fit_found ? ST_A_FIND : ST_DONE;
            ST_A_FIND:
            begin
                if (!k_found)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = (k_sel == v_reg) ? ST_T_RD : ST_S_RD;
                end
            end
            ST_S_RD:    state_next = ST_S_GET;
            ST_S_GET:
            begin
                state_next = ST_U_PREV;
                ret_next   = ST_S_PUSHR;
            end
            ST_S_PUSHR:
            begin
                state_next = ST_P_HEAD;
                ret_next   = ST_S_PUSHL;
            end
            ST_S_PUSHL:
            begin
                state_next = ST_P_HEAD;
                ret_next   = ST_S_NEXT;
            end
            ST_S_NEXT:  state_next = ((k_reg - lvl_t'(1)) > v_reg) ? ST_S_RD : ST_T_RD;
            ST_T_RD:    state_next = ST_T_GET;
            ST_T_GET:
            begin
                state_next = ST_U_PREV;
                ret_next   = ST_T_FIN;
            end
            ST_T_FIN:   state_next = ST_DONE;
            ST_R_DIV:   state_next = ST_R_CHK;
            ST_R_CHK:   state_next = rel_chk_ok ? ST_R_GET : ST_DONE;
            ST_R_GET:
            begin
                if (bh.valid && bh.used)
                begin
                    state_next = ST_P_HEAD;
                    ret_next   = ST_M_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_M_RD:    state_next = ST_M_GET;
            ST_M_GET:   state_next = ST_M_BUD;
            ST_M_BUD:   state_next = (merge_go && bud_ok) ? ST_M_CHK : ST_DONE;
            ST_M_CHK:
            begin
                if (bud_match)
                begin
                    state_next = ST_U_PREV;
                    ret_next   = ST_M_SWAP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_M_SWAP:  state_next = ST_M_GETB;
            ST_M_GETB:
            begin
                state_next = ST_U_PREV;
                ret_next   = ST_M_JOIN;
            end
            ST_M_JOIN:
            begin
                state_next = ST_P_HEAD;
                ret_next   = ST_M_RD;
            end
            ST_U_PREV:  state_next = hdr_reg.has_prev ? ST_U_PREVW : ST_U_NEXT;
            ST_U_PREVW: state_next = ST_U_NEXT;
            ST_U_NEXT:  state_next = hdr_reg.has_next ? ST_U_NEXTW : ST_U_END;
            ST_U_NEXTW: state_next = ST_U_END;
            ST_U_END:   state_next = ret_reg;
            ST_P_HEAD:  state_next = head_ok_sel ? ST_P_HEADW : ST_P_END;
            ST_P_HEADW: state_next = ST_P_END;
            ST_P_END:   state_next = ret_reg;
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
            ret_next   = ST_IDLE;
        end
    end

    // Datapath and memory control
    always_comb
    begin
        hdr_t  tmp_h;
        hdr_t  left_h;
        hdr_t  right_h;
        unit_t left_a;
        unit_t right_a;
        lvl_t  half_l;

        top_next        = top_reg;
        head_ok_next    = head_ok_reg;
        head_at_next    = head_at_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        len_next        = len_reg;
        rel_next        = rel_reg;
        u_next          = u_reg;
        aux_next        = aux_reg;
        hdr_next        = hdr_reg;
        save_next       = save_reg;
        v_next          = v_reg;
        k_next          = k_reg;
        q_next          = q_reg;
        u5_next         = u5_reg;
        rel_ok_next     = rel_ok_reg;
        mem_we          = 1'b0;
        mem_waddr       = u_reg;
        mem_wdata       = hdr_reg;
        mem_raddr       = u_reg;
        tmp_h           = hdr_reg;
        left_h          = hdr_reg;
        right_h         = save_reg;
        left_a          = u_reg;
        right_a         = aux_reg;
        half_l          = cur_lvl - lvl_t'(1);

        case (state_reg)
            // Write one header a cycle, root block at unit 0
            ST_CLEAR:
            begin
                tmp_h = '0;
                if (clr_reg == '0)
                begin
                    tmp_h.valid   = 1'b1;
                    tmp_h.level   = top_reg;
                    tmp_h.side    = SIDE_ROOT;
                    tmp_h.inherit = SIDE_ROOT;
                end
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = tmp_h;
                clr_next  = clr_reg + unit_t'(1);
            end
            // Capture the request word
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    len_next        = req.request_length;
                    rel_next        = req.release_address;
                    res_addr_next   = '0;
                    res_status_next = STATUS_OK;
                    if ((req.op == OP_RELEASE) && (req.release_address == '0))
                    begin
                        res_status_next = STATUS_NULL;
                    end
                end
            end
            ST_A_FIT:
            begin
                v_next = fit_v;
                if (!fit_found)
                begin
                    res_status_next = STATUS_NOFIT;
                end
            end
            ST_A_FIND:
            begin
                k_next = k_sel;
                if (!k_found)
                begin
                    res_status_next = STATUS_NOFIT;
                end
            end
            ST_S_RD, ST_T_RD:
            begin
                mem_raddr = head_at_sel;
                u_next    = head_at_sel;
            end
            ST_S_GET, ST_T_GET, ST_M_GET:
            begin
                hdr_next = bh;
            end
            // Split: right half first, left half kept aside
            ST_S_PUSHR:
            begin
                left_h          = hdr_reg;
                left_h.inherit  = hdr_reg.side;
                left_h.side     = SIDE_LEFT;
                left_h.level    = half_l;
                left_h.used     = 1'b0;
                right_h         = '0;
                right_h.valid   = 1'b1;
                right_h.level   = half_l;
                right_h.side    = SIDE_RIGHT;
                right_h.inherit = hdr_reg.inherit;
                save_next       = left_h;
                hdr_next        = right_h;
                aux_next        = u_reg;
                u_next          = u_reg + (unit_t'(1) << half_l);
            end
            ST_S_PUSHL:
            begin
                hdr_next = save_reg;
                u_next   = aux_reg;
            end
            ST_S_NEXT:
            begin
                k_next = k_reg - lvl_t'(1);
            end
            ST_T_FIN:
            begin
                tmp_h         = hdr_reg;
                tmp_h.used    = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = u_reg;
                mem_wdata     = tmp_h;
                res_addr_next = alloc_addr;
            end
            // Release: divide the offset by the block size
            ST_R_DIV:
            begin
                q_next      = off[ADDR_W-1:3];
                u5_next     = prod[PROD_W-1:RECIP5_SHIFT];
                rel_ok_next = (rel_reg >= ADDR_W'(ADDR_BIAS)) && (off[2:0] == '0);
            end
            ST_R_CHK:
            begin
                u_next    = u5_reg[UNIT_W-1:0];
                mem_raddr = u5_reg[UNIT_W-1:0];
            end
            ST_R_GET:
            begin
                tmp_h      = bh;
                tmp_h.used = 1'b0;
                hdr_next   = tmp_h;
            end
            ST_M_RD:
            begin
                mem_raddr = u_reg;
            end
            ST_M_BUD:
            begin
                mem_raddr = bud_addr;
                aux_next  = bud_addr;
            end
            // Store the unlinked block, fetch its buddy fresh
            ST_M_SWAP:
            begin
                mem_we    = 1'b1;
                mem_waddr = u_reg;
                mem_wdata = hdr_reg;
                mem_raddr = aux_reg;
                save_next = hdr_reg;
            end
            ST_M_GETB:
            begin
                hdr_next = bh;
                u_next   = aux_reg;
                aux_next = u_reg;
            end
            // Join the pair into the left block, drop the right one
            ST_M_JOIN:
            begin
                if (save_reg.side == SIDE_LEFT)
                begin
                    left_h  = save_reg;
                    right_h = hdr_reg;
                    left_a  = aux_reg;
                    right_a = u_reg;
                end
                else
                begin
                    left_h  = hdr_reg;
                    right_h = save_reg;
                    left_a  = u_reg;
                    right_a = aux_reg;
                end
                tmp_h          = left_h;
                tmp_h.level    = left_h.level + lvl_t'(1);
                tmp_h.side     = left_h.inherit;
                tmp_h.inherit  = right_h.inherit;
                hdr_next       = tmp_h;
                u_next         = left_a;
                right_h.valid  = 1'b0;
                mem_we         = 1'b1;
                mem_waddr      = right_a;
                mem_wdata      = right_h;
            end
            // Unlink: patch the previous block or the list head, then the next block
            ST_U_PREV:
            begin
                if (hdr_reg.has_prev)
                begin
                    mem_raddr = hdr_reg.prev;
                end
                else
                begin
                    head_ok_next[cur_lvl] = hdr_reg.has_next;
                    head_at_next[cur_lvl] = hdr_reg.next;
                end
            end
            ST_U_PREVW:
            begin
                tmp_h          = bh;
                tmp_h.has_next = hdr_reg.has_next;
                tmp_h.next     = hdr_reg.next;
                mem_we         = 1'b1;
                mem_waddr      = hdr_reg.prev;
                mem_wdata      = tmp_h;
            end
            ST_U_NEXT:
            begin
                mem_raddr = hdr_reg.next;
            end
            ST_U_NEXTW:
            begin
                tmp_h          = bh;
                tmp_h.has_prev = hdr_reg.has_prev;
                tmp_h.prev     = hdr_reg.prev;
                mem_we         = 1'b1;
                mem_waddr      = hdr_reg.next;
                mem_wdata      = tmp_h;
            end
            ST_U_END:
            begin
                tmp_h          = hdr_reg;
                tmp_h.has_next = 1'b0;
                tmp_h.has_prev = 1'b0;
                tmp_h.next     = '0;
                tmp_h.prev     = '0;
                hdr_next       = tmp_h;
            end
            // Push: link in front of the current head
            ST_P_HEAD:
            begin
                tmp_h          = hdr_reg;
                tmp_h.has_prev = 1'b0;
                tmp_h.prev     = '0;
                tmp_h.has_next = head_ok_sel;
                tmp_h.next     = head_ok_sel ? head_at_sel : unit_t'(0);
                hdr_next       = tmp_h;
                mem_raddr      = head_at_sel;
            end
            ST_P_HEADW:
            begin
                tmp_h          = bh;
                tmp_h.has_prev = 1'b1;
                tmp_h.prev     = u_reg;
                mem_we         = 1'b1;
                mem_waddr      = head_at_sel;
                mem_wdata      = tmp_h;
            end
            ST_P_END:
            begin
                mem_we                = 1'b1;
                mem_waddr             = u_reg;
                mem_wdata             = hdr_reg;
                head_ok_next[cur_lvl] = 1'b1;
                head_at_next[cur_lvl] = u_reg;
            end
            // Hand the result to the output register
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase

        // Rebuild the arena on a level write
        if (cfg_we)
        begin
            top_next     = bba_sat(cfg_wdata);
            head_ok_next = '0;
            head_ok_next[bba_sat(cfg_wdata)] = 1'b1;
            for (int i = 0; i < HEADS; i++)
            begin
                head_at_next[i] = '0;
            end
            clr_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ret_reg       <= ST_IDLE;
            top_reg       <= lvl_t'(MAX_LEVEL);
            head_ok_reg   <= HEADS'(1) << MAX_LEVEL;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HEADS; i++)
            begin
                head_at_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            top_reg       <= top_next;
            head_ok_reg   <= head_ok_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            head_at_reg   <= head_at_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        len_reg        <= len_next;
        rel_reg        <= rel_next;
        u_reg          <= u_next;
        aux_reg        <= aux_next;
        hdr_reg        <= hdr_next;
        save_reg       <= save_next;
        v_reg          <= v_next;
        k_reg          <= k_next;
        q_reg          <= q_next;
        u5_reg         <= u5_next;
        rel_ok_reg     <= rel_ok_next;
    end

    // Checks
    `BBA_ASSERT_NOW(a_clear_blocks_req, state_reg == ST_CLEAR, !req.ready,
        "request taken during clearing pass")
    `BBA_ASSERT_NOW(a_heads_within_arena, 1'b1, (head_ok_reg & above_top_mask) == '0,
        "free list above arena level")
    `BBA_ASSERT_NEXT(a_accept_starts_work, req.valid && req.ready, !req.ready,
        "second word taken before the first finished")
    `BBA_ASSERT_NOW(a_null_release_zero, out_valid_reg && (out_status_reg == STATUS_NULL),
        out_addr_reg == '0, "null release returned an address")

endmodule

// File: rtl/bba_ram.sv
module bba_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
